// ===== design/acked_batch_sender_core_defines.svh =====
// Assertion macros shared by the sender design.
// Each macro expects signals named clk and rst_n in the scope of its use.
`ifndef ACKED_BATCH_SENDER_CORE_DEFINES_SVH
`define ACKED_BATCH_SENDER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/abs_pkg.sv =====
package abs_pkg;

    localparam int PULSE_W    = 32;
    localparam int SEQ_W      = 8;
    localparam int REQ_W      = 3;
    localparam int OUT_CNT_W  = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 80;

    localparam logic [SEQ_W-1:0] SEQ_FIRST = 8'd1;
    localparam logic [SEQ_W-1:0] SEQ_LAST  = 8'd255;

    typedef enum logic [REQ_W-1:0] {
        REQ_CAPTURE   = 3'd0,
        REQ_POWER_ON  = 3'd1,
        REQ_POWER_OFF = 3'd2,
        REQ_REPORT    = 3'd3,
        REQ_ACK       = 3'd4,
        REQ_RESET     = 3'd5
    } req_kind_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [PULSE_W-1:0] pulse_count;
        logic [SEQ_W-1:0]   ack_seq;
    } event_t;

    typedef struct packed {
        logic [SEQ_W-1:0]     batch_seq;
        logic                 batch_samples;
        logic [OUT_CNT_W-1:0] batch_captures;
        logic [OUT_CNT_W-1:0] batch_pulses;
    } batch_t;

    // Status handed from the event logic to the output register.
    typedef struct packed {
        logic   load;
        batch_t batch;
    } result_t;

    function automatic logic [SEQ_W-1:0] seq_step(input logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] nxt;
        begin
            nxt = (seq == SEQ_LAST) ? SEQ_FIRST : seq + SEQ_FIRST;
            return nxt;
        end
    endfunction

endpackage

// ===== design/abs_event_core.sv =====
module abs_event_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             evt_valid,
    input  abs_pkg::event_t  evt,
    output abs_pkg::result_t result
);

    logic [COUNT_WIDTH-1:0]    running_total_reg, running_total_next;
    logic [COUNT_WIDTH-1:0]    capture_tally_reg, capture_tally_next;
    logic [COUNT_WIDTH-1:0]    acked_mark_reg, acked_mark_next;
    logic                      cutoff_valid_reg, cutoff_valid_next;
    logic [COUNT_WIDTH-1:0]    cutoff_total_reg, cutoff_total_next;
    logic [COUNT_WIDTH-1:0]    cutoff_captures_reg, cutoff_captures_next;
    logic                      batch_pending_reg, batch_pending_next;
    logic [COUNT_WIDTH-1:0]    held_pulses_reg, held_pulses_next;
    logic [COUNT_WIDTH-1:0]    held_captures_reg, held_captures_next;
    logic                      held_samples_reg, held_samples_next;
    logic [abs_pkg::SEQ_W-1:0] held_seq_reg, held_seq_next;
    logic [abs_pkg::SEQ_W-1:0] next_sequence_reg, next_sequence_next;

    logic [COUNT_WIDTH-1:0]    eff_total;
    logic [COUNT_WIDTH-1:0]    eff_captures;
    logic [COUNT_WIDTH-1:0]    new_pulses;
    logic                      new_samples;
    logic [63:0]               out_pulses_ext;
    logic [63:0]               out_captures_ext;
    logic                      emit_batch;
    abs_pkg::req_kind_t        kind;

    assign kind = abs_pkg::req_kind_t'(evt.req_type);

    // Without a frozen cutoff a data request with no batch pending freezes one on the fly.
    assign eff_total    = cutoff_valid_reg ? cutoff_total_reg : running_total_reg;
    assign eff_captures = cutoff_valid_reg ? cutoff_captures_reg : capture_tally_reg;
    assign new_pulses   = eff_total - acked_mark_reg;
    assign new_samples  = (new_pulses != '0);

    always_comb
    begin
        running_total_next   = running_total_reg;
        capture_tally_next   = capture_tally_reg;
        acked_mark_next      = acked_mark_reg;
        cutoff_valid_next    = cutoff_valid_reg;
        cutoff_total_next    = cutoff_total_reg;
        cutoff_captures_next = cutoff_captures_reg;
        batch_pending_next   = batch_pending_reg;
        held_pulses_next     = held_pulses_reg;
        held_captures_next   = held_captures_reg;
        held_samples_next    = held_samples_reg;
        held_seq_next        = held_seq_reg;
        next_sequence_next   = next_sequence_reg;
        emit_batch           = 1'b0;

        if (evt_valid)
        begin
            case (kind)
                abs_pkg::REQ_CAPTURE:
                begin
                    running_total_next = running_total_reg
                                         + COUNT_WIDTH'(64'(evt.pulse_count));
                    capture_tally_next = capture_tally_reg + COUNT_WIDTH'(1);
                end
                abs_pkg::REQ_POWER_ON:
                begin
                    cutoff_total_next    = running_total_reg;
                    cutoff_captures_next = capture_tally_reg;
                    cutoff_valid_next    = 1'b1;
                end
                abs_pkg::REQ_POWER_OFF:
                begin
                    cutoff_valid_next = 1'b0;
                end
                abs_pkg::REQ_REPORT:
                begin
                    emit_batch = 1'b1;
                    if (!batch_pending_reg)
                    begin
                        cutoff_total_next    = eff_total;
                        cutoff_captures_next = eff_captures;
                        cutoff_valid_next    = 1'b1;
                        held_pulses_next     = new_pulses;
                        held_captures_next   = eff_captures;
                        held_samples_next    = new_samples;
                        held_seq_next        = next_sequence_reg;
                        next_sequence_next   = abs_pkg::seq_step(next_sequence_reg);
                        batch_pending_next   = new_samples;
                    end
                end
                abs_pkg::REQ_ACK:
                begin
                    if (batch_pending_reg && evt.ack_seq == held_seq_reg)
                    begin
                        acked_mark_next    = acked_mark_reg + held_pulses_reg;
                        batch_pending_next = 1'b0;
                    end
                end
                abs_pkg::REQ_RESET:
                begin
                    cutoff_valid_next  = 1'b0;
                    batch_pending_next = 1'b0;
                    next_sequence_next = abs_pkg::SEQ_FIRST;
                    acked_mark_next    = running_total_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The result is the held batch after this event's update.
    assign out_pulses_ext   = 64'(held_pulses_next);
    assign out_captures_ext = 64'(held_captures_next);
    assign result.load                 = emit_batch;
    assign result.batch.batch_pulses   = out_pulses_ext[abs_pkg::OUT_CNT_W-1:0];
    assign result.batch.batch_captures = out_captures_ext[abs_pkg::OUT_CNT_W-1:0];
    assign result.batch.batch_samples  = held_samples_next;
    assign result.batch.batch_seq      = held_seq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_total_reg   <= '0;
            capture_tally_reg   <= '0;
            acked_mark_reg      <= '0;
            cutoff_valid_reg    <= 1'b0;
            cutoff_total_reg    <= '0;
            cutoff_captures_reg <= '0;
            batch_pending_reg   <= 1'b0;
            held_pulses_reg     <= '0;
            held_captures_reg   <= '0;
            held_samples_reg    <= 1'b0;
            held_seq_reg        <= '0;
            next_sequence_reg   <= abs_pkg::SEQ_FIRST;
        end
        else
        begin
            running_total_reg   <= running_total_next;
            capture_tally_reg   <= capture_tally_next;
            acked_mark_reg      <= acked_mark_next;
            cutoff_valid_reg    <= cutoff_valid_next;
            cutoff_total_reg    <= cutoff_total_next;
            cutoff_captures_reg <= cutoff_captures_next;
            batch_pending_reg   <= batch_pending_next;
            held_pulses_reg     <= held_pulses_next;
            held_captures_reg   <= held_captures_next;
            held_samples_reg    <= held_samples_next;
            held_seq_reg        <= held_seq_next;
            next_sequence_reg   <= next_sequence_next;
        end
    end

endmodule

// ===== design/abs_out_reg.sv =====
module abs_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  abs_pkg::result_t result,
    output logic             out_ready,
    output logic             out_valid,
    input  logic             out_taken,
    output abs_pkg::batch_t  out_batch
);

    logic            valid_reg;
    abs_pkg::batch_t batch_reg;

    // A new batch may load in the same cycle the previous one is taken.
    assign out_ready = !valid_reg || out_taken;
    assign out_valid = valid_reg;
    assign out_batch = batch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (result.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_taken)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            batch_reg <= result.batch;
        end
    end

endmodule

// ===== design/acked_batch_sender_core.sv =====
// Channel    Direction  tdata                                        tuser
// s_axis     in         pulse_count[31:0] ack_seq[39:32]             req_type[2:0]
// m_axis     out        batch_pulses[31:0] batch_captures[63:32]     none
//                       batch_samples[64] batch_seq[72:65]
// One event is taken per cycle while no data request is stalled. An event is held in the
// input register and applied to the link state as it leaves it; a data request's batch is
// loaded into the output register at that same edge, from which m_axis offers it.
// A held batch in the output register stalls only a data request behind it, and with
// it the input; other events keep flowing. Reset is asynchronous and clears every
// counter and flag, with the sequence restarting at 1.
`include "acked_batch_sender_core_defines.svh"

module acked_batch_sender_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // pulse_count, ack_seq
    input  logic [2:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // batch_pulses, batch_captures, batch_samples,
                                        // batch_seq, zero fill
);

    logic             in_valid_reg;
    abs_pkg::event_t  in_item_reg;
    logic             advance;
    logic             out_ready;
    logic             out_taken;
    abs_pkg::result_t result;
    abs_pkg::batch_t  out_batch;
    logic             is_request;

    assign is_request    = (abs_pkg::req_kind_t'(in_item_reg.req_type) == abs_pkg::REQ_REPORT);
    assign advance       = in_valid_reg && (!is_request || out_ready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign out_taken     = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.req_type    <= s_axis_tuser;
            in_item_reg.pulse_count <= s_axis_tdata[31:0];
            in_item_reg.ack_seq     <= s_axis_tdata[39:32];
        end
    end

    abs_event_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_event_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt_valid(advance),
        .evt      (in_item_reg),
        .result   (result)
    );

    abs_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .result   (result),
        .out_ready(out_ready),
        .out_valid(m_axis_tvalid),
        .out_taken(out_taken),
        .out_batch(out_batch)
    );

    assign m_axis_tdata = {7'd0, out_batch.batch_seq, out_batch.batch_samples,
                           out_batch.batch_captures, out_batch.batch_pulses};

    `ABS_ASSERT_SAME(a_seq_nonzero, m_axis_tvalid, m_axis_tdata[72:65] != 8'd0,
        "batch sequence number is zero")
    `ABS_ASSERT_SAME(a_empty_no_pulses, m_axis_tvalid && !m_axis_tdata[64],
        m_axis_tdata[31:0] == 32'd0, "empty batch carries pulses")
    `ABS_ASSERT_SAME(a_stall_blocks_input, in_valid_reg && !advance, !s_axis_tready,
        "input taken while the held event is stalled")
    `ABS_ASSERT_NEXT(a_request_loads_output, advance && is_request, m_axis_tvalid,
        "data request left no batch in the output register")

endmodule

// ===== test/tb_acked_batch_sender_core.sv =====
`timescale 1ns / 1ps

module tb_acked_batch_sender_core;

    // Request codes that the block must ignore.
    localparam logic [abs_pkg::REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [abs_pkg::REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLDOFF_LEN   = 300;
    localparam int RANDOM_ITEMS  = 200;
    localparam int STEADY_ITEMS  = 100;
    localparam int DRAIN_CYCLES  = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // pulse_count, ack_seq
    logic [2:0]  s_axis_tuser = '0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // batch_pulses, batch_captures, batch_samples,
                                      // batch_seq, zero fill

    // Link state as the testbench tracks it.
    logic [abs_pkg::PULSE_W-1:0] run_total;
    logic [abs_pkg::PULSE_W-1:0] cap_tally;
    logic [abs_pkg::PULSE_W-1:0] ack_mark;
    logic                        frz_on;
    logic [abs_pkg::PULSE_W-1:0] frz_sum;
    logic [abs_pkg::PULSE_W-1:0] frz_count;
    logic                        batch_held;
    abs_pkg::batch_t             held_batch;
    logic [abs_pkg::SEQ_W-1:0]   seq_counter;

    abs_pkg::batch_t expected_batches[$];

    int unsigned error_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned sent_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned rx_hold_request = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;

    acked_batch_sender_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Updates the tracked link state for one event and queues the batch it reports.
    task automatic track_event(input logic [abs_pkg::REQ_W-1:0] kind,
                               input logic [abs_pkg::PULSE_W-1:0] pulses,
                               input logic [abs_pkg::SEQ_W-1:0] aseq);
        case (kind)
            abs_pkg::REQ_CAPTURE:
            begin
                run_total = run_total + pulses;
                cap_tally = cap_tally + 1'b1;
            end
            abs_pkg::REQ_POWER_ON:
            begin
                frz_sum   = run_total;
                frz_count = cap_tally;
                frz_on    = 1'b1;
            end
            abs_pkg::REQ_POWER_OFF:
                frz_on = 1'b0;
            abs_pkg::REQ_REPORT:
            begin
                if (!batch_held)
                begin
                    if (!frz_on)
                    begin
                        frz_sum   = run_total;
                        frz_count = cap_tally;
                        frz_on    = 1'b1;
                    end
                    held_batch.batch_pulses   = frz_sum - ack_mark;
                    held_batch.batch_captures = frz_count;
                    held_batch.batch_samples  = (held_batch.batch_pulses != '0);
                    held_batch.batch_seq      = seq_counter;
                    seq_counter = (seq_counter == abs_pkg::SEQ_LAST) ? abs_pkg::SEQ_FIRST
                                                                     : seq_counter + 1'b1;
                    // An empty batch is reported but never waits for an acknowledge.
                    batch_held = held_batch.batch_samples;
                end
                expected_batches.push_back(held_batch);
            end
            abs_pkg::REQ_ACK:
            begin
                if (batch_held && aseq == held_batch.batch_seq)
                begin
                    ack_mark   = ack_mark + held_batch.batch_pulses;
                    batch_held = 1'b0;
                end
            end
            abs_pkg::REQ_RESET:
            begin
                frz_on      = 1'b0;
                batch_held  = 1'b0;
                seq_counter = abs_pkg::SEQ_FIRST;
                ack_mark    = run_total;
            end
            default:
                ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            track_event(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32]);
    end

    always @(posedge clk)
    begin : check_batches
        abs_pkg::batch_t got;
        abs_pkg::batch_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = abs_pkg::batch_t'(m_axis_tdata[72:0]);
            if (expected_batches.size() == 0)
            begin
                error_count++;
                if (mismatch_count < 10)
                    $display("ERROR: batch seq %0d arrived with none expected", got.batch_seq);
                mismatch_count++;
            end
            else
            begin
                want = expected_batches.pop_front();
                if (got.batch_pulses !== want.batch_pulses
                        || got.batch_captures !== want.batch_captures
                        || got.batch_samples !== want.batch_samples
                        || got.batch_seq !== want.batch_seq)
                begin
                    error_count++;
                    // Fields are pulses, captures, samples and sequence number.
                    if (mismatch_count < 10)
                        $display("ERROR: expected %h %h %b %0d, got %h %h %b %0d",
                                 want.batch_pulses, want.batch_captures, want.batch_samples,
                                 want.batch_seq, got.batch_pulses, got.batch_captures,
                                 got.batch_samples, got.batch_seq);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when no transfer has happened on either side for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    initial
    begin : receiver
        int unsigned hold_len;
        forever
        begin
            @(negedge clk);
            if (rx_hold_request > 0)
            begin
                hold_len = rx_hold_request;
                rx_hold_request = 0;
                m_axis_tready <= 1'b0;
                for (int unsigned i = 1; i < hold_len; i++)
                    @(negedge clk);
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                hold_len = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                for (int unsigned i = 1; i < hold_len; i++)
                    @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offers one event and returns at the falling edge after its transfer.
    task automatic send_event(input logic [abs_pkg::REQ_W-1:0] kind,
                              input logic [abs_pkg::PULSE_W-1:0] pulses,
                              input logic [abs_pkg::SEQ_W-1:0] aseq);
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {aseq, pulses};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
        @(negedge clk);
    endtask

    function automatic logic [abs_pkg::SEQ_W-1:0] rand_seq();
        logic [31:0] r;
        r = $urandom;
        return r[abs_pkg::SEQ_W-1:0];
    endfunction

    function automatic logic [abs_pkg::REQ_W-1:0] rand_kind();
        logic [31:0] r;
        r = $urandom_range(0, 7);
        return r[abs_pkg::REQ_W-1:0];
    endfunction

    function automatic logic [abs_pkg::PULSE_W-1:0] pick_pulses();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1, 255);
            3:       return 32'hFFFF_FF00 + $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Mostly a full capture, request and acknowledge exchange; sometimes noise.
    task automatic send_traffic_cycle();
        int unsigned pick;
        logic [abs_pkg::SEQ_W-1:0] aseq;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            repeat ($urandom_range(0, 4))
                send_event(abs_pkg::REQ_CAPTURE, pick_pulses(), rand_seq());
            if ($urandom_range(0, 1))
                send_event(abs_pkg::REQ_POWER_ON, $urandom, rand_seq());
            send_event(abs_pkg::REQ_REPORT, $urandom, rand_seq());
            if ($urandom_range(0, 3) == 0)
                send_event(abs_pkg::REQ_REPORT, $urandom, rand_seq());
            if ($urandom_range(0, 4) == 0)
                send_event(abs_pkg::REQ_POWER_OFF, $urandom, rand_seq());
            pick = $urandom_range(0, 9);
            aseq = (pick < 8) ? held_batch.batch_seq : rand_seq();
            if (pick < 9)
                send_event(abs_pkg::REQ_ACK, $urandom, aseq);
        end
        else if (pick < 85)
            send_event(rand_kind(), $urandom, rand_seq());
        else if (pick < 90)
            send_event(abs_pkg::REQ_RESET, $urandom, rand_seq());
        else
            send_event((pick % 2) ? abs_pkg::REQ_POWER_ON : abs_pkg::REQ_POWER_OFF,
                       $urandom, rand_seq());
    endtask

    task automatic test_directed();
        send_event(abs_pkg::REQ_REPORT, '0, '0);        // no cutoff yet, empty batch
        send_event(abs_pkg::REQ_ACK, '0, 8'd1);         // nothing pending
        send_event(abs_pkg::REQ_CAPTURE, '0, '0);
        send_event(abs_pkg::REQ_CAPTURE, '1, 8'hFF);
        send_event(abs_pkg::REQ_CAPTURE, 32'd5, '0);    // running total wraps
        send_event(abs_pkg::REQ_POWER_ON, '1, '1);
        send_event(abs_pkg::REQ_CAPTURE, 32'd100, '0);
        send_event(abs_pkg::REQ_REPORT, '0, '0);
        send_event(abs_pkg::REQ_REPORT, '1, '1);        // resend unchanged
        send_event(abs_pkg::REQ_ACK, '0, '0);           // wrong sequence
        send_event(abs_pkg::REQ_POWER_OFF, '0, '0);     // pending batch survives
        send_event(abs_pkg::REQ_REPORT, '0, '0);
        send_event(abs_pkg::REQ_ACK, '0, 8'hFF);
        send_event(abs_pkg::REQ_ACK, '0, held_batch.batch_seq);
        send_event(abs_pkg::REQ_REPORT, '0, '0);        // freezes a new cutoff itself
        send_event(REQ_UNUSED_LO, '1, '1);
        send_event(REQ_UNUSED_HI, '1, '1);
        send_event(abs_pkg::REQ_ACK, '0, held_batch.batch_seq);
        send_event(abs_pkg::REQ_RESET, '0, '0);
        send_event(abs_pkg::REQ_REPORT, '0, '0);
        send_event(abs_pkg::REQ_CAPTURE, 32'h8000_0000, 8'hAA);
        send_event(abs_pkg::REQ_POWER_ON, '0, '0);
        send_event(abs_pkg::REQ_REPORT, '0, '0);
        send_event(abs_pkg::REQ_RESET, '0, '0);         // drops the pending batch
        send_event(abs_pkg::REQ_REPORT, '0, '0);
    endtask

    // Empty batches each take a sequence number, so enough of them wrap it.
    task automatic test_sequence_wrap();
        send_event(abs_pkg::REQ_RESET, '0, '0);
        repeat (258) send_event(abs_pkg::REQ_REPORT, $urandom, rand_seq());
        send_event(abs_pkg::REQ_CAPTURE, pick_pulses(), '0);
        send_event(abs_pkg::REQ_REPORT, '0, '0);
        send_event(abs_pkg::REQ_ACK, '0, held_batch.batch_seq);
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at)
        begin
            // Alternate stretches with and without idling.
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            repeat (4) send_traffic_cycle();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // The receiver stops for a long stretch while requests keep coming, so the
    // output fills and the input stalls behind it.
    task automatic test_output_holdoff();
        rx_hold_request = HOLDOFF_LEN;
        tx_idle_en = 1'b0;
        repeat (4)
        begin
            send_event(abs_pkg::REQ_CAPTURE, pick_pulses(), rand_seq());
            send_event(abs_pkg::REQ_REPORT, $urandom, rand_seq());
            send_event(abs_pkg::REQ_REPORT, $urandom, rand_seq());
            send_event(abs_pkg::REQ_ACK, $urandom, held_batch.batch_seq);
        end
        tx_idle_en = 1'b1;
    endtask

    task automatic test_steady_stream();
        int unsigned stop_at;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        stop_at = sent_count + STEADY_ITEMS;
        while (sent_count < stop_at)
            send_traffic_cycle();
    endtask

    initial
    begin
        run_total   = '0;
        cap_tally   = '0;
        ack_mark    = '0;
        frz_on      = 1'b0;
        frz_sum     = '0;
        frz_count   = '0;
        batch_held  = 1'b0;
        held_batch  = '0;
        seq_counter = abs_pkg::SEQ_FIRST;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_sequence_wrap();
        test_random_traffic();
        test_output_holdoff();
        test_steady_stream();

        s_axis_tvalid <= 1'b0;
        while (expected_batches.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_batches.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
